FILE: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

FILE: src/cdtm_pkg.sv
// Shared constants, types and helpers of the counter delta template matcher
package cdtm_pkg;

   localparam int SLOTS    = 12;
   localparam int SLOT_W   = 4;
   localparam int ENTRIES  = 128;
   localparam int ENTRY_W  = 7;
   localparam int COUNT_W  = 8;
   localparam int WORDS    = ENTRIES * SLOTS;
   localparam int ADDR_W   = 11;
   localparam int CTR_W    = 32;
   localparam int SUM1_W   = 33;
   localparam int DIST_W   = 37;
   localparam int THR_W    = 31;
   localparam int HOLD_W   = 20;
   localparam int TIME_W   = 64;
   localparam int HIST_W   = 7;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [HIST_W-1:0]  HIST_DEPTH   = 7'd100;
   localparam logic [HOLD_W-1:0]  HOLD_RESET   = 20'd80000;
   localparam logic [COUNT_W-1:0] ENTRY_RESET  = 8'd128;
   localparam logic [COUNT_W-1:0] ENTRY_MAX    = 8'd128;
   localparam logic [SLOT_W-1:0]  SLOT_LAST    = 4'd11;
   localparam logic [SLOT_W-1:0]  SLOT_LIMIT   = 4'd12;

   // Commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Register indexes (word address bits)
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_HOLD_OFF  = 2'd1;
   localparam logic [1:0] REG_ENTRIES   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [HOLD_W-1:0]  hold_off;
      logic [COUNT_W-1:0] entries;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic use_prev;
   } dist_ctl_type;

   // entry * 12 + slot, built from shifts
   function automatic logic [ADDR_W-1:0] word_addr(input logic [ENTRY_W-1:0] entry,
                                                   input logic [SLOT_W-1:0] slot);
      word_addr = {1'b0, entry, 3'b000} + {2'b00, entry, 2'b00} + {7'b0, slot};
   endfunction

endpackage

FILE: src/cdtm_req_if.sv
// Input channel: template loads and counter readings
interface cdtm_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [cdtm_pkg::ENTRY_W-1:0]   entry_index;
   logic [cdtm_pkg::SLOT_W-1:0]    slot;
   logic [cdtm_pkg::CTR_W-1:0]     value;
   logic [cdtm_pkg::TIME_W-1:0]    time_us;
   logic                           last_slot;

   modport source (output valid, command, entry_index, slot, value, time_us, last_slot,
                   input ready);
   modport sink (input valid, command, entry_index, slot, value, time_us, last_slot,
                 output ready);
endinterface

FILE: src/cdtm_rsp_if.sv
// Result channel: one outcome per closed sample
interface cdtm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         active;
   logic                         suppressed;
   logic                         matched;
   logic                         via_combine;
   logic [cdtm_pkg::ENTRY_W-1:0] match_entry;

   modport source (output valid, active, suppressed, matched, via_combine, match_entry,
                   input ready);
   modport sink (input valid, active, suppressed, matched, via_combine, match_entry,
                 output ready);
endinterface

FILE: src/cdtm_csr.sv
// Configuration registers behind the APB-style port
module cdtm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cdtm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [cdtm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [cdtm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output cdtm_pkg::cfg_type             cfg
);

   cdtm_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= '0;
         cfg_ff.hold_off  <= cdtm_pkg::HOLD_RESET;
         cfg_ff.entries   <= cdtm_pkg::ENTRY_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            cdtm_pkg::REG_THRESHOLD: cfg_ff.threshold <= csr_pwdata[cdtm_pkg::THR_W-1:0];
            cdtm_pkg::REG_HOLD_OFF:  cfg_ff.hold_off  <= csr_pwdata[cdtm_pkg::HOLD_W-1:0];
            cdtm_pkg::REG_ENTRIES:   cfg_ff.entries   <= csr_pwdata[cdtm_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         cdtm_pkg::REG_THRESHOLD: csr_prdata = {1'b0, cfg_ff.threshold};
         cdtm_pkg::REG_HOLD_OFF:  csr_prdata = {12'b0, cfg_ff.hold_off};
         cdtm_pkg::REG_ENTRIES:   csr_prdata = {24'b0, cfg_ff.entries};
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

FILE: src/cdtm_tmpl_ram.sv
// Template word store: one write port, one registered read port
module cdtm_tmpl_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cdtm_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [cdtm_pkg::CTR_W-1:0]    wr_data,
   input  logic [cdtm_pkg::ADDR_W-1:0]   rd_addr,
   output logic [cdtm_pkg::CTR_W-1:0]    rd_data
);

   logic [cdtm_pkg::CTR_W-1:0] mem [cdtm_pkg::WORDS];
   logic [cdtm_pkg::CTR_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

FILE: src/cdtm_dist_unit.sv
// Shared L1 distance unit: one absolute difference and accumulate per cycle while ctl.valid is set
module cdtm_dist_unit (
   input  logic                          clock,
   input  cdtm_pkg::dist_ctl_type        ctl,
   input  logic [cdtm_pkg::CTR_W-1:0]    tmpl_word,
   input  logic [cdtm_pkg::CTR_W-1:0]    delta,
   input  logic [cdtm_pkg::CTR_W-1:0]    prev_delta,
   input  logic [cdtm_pkg::THR_W-1:0]    threshold,
   output logic                          hit
);

   logic [cdtm_pkg::DIST_W-1:0] acc_ff, acc_in, base, sum;
   logic [cdtm_pkg::SUM1_W-1:0] operand, tword, diff;

   // combined delta never overflows 33 bits, so no saturation needed
   always_comb begin
      operand = ctl.use_prev ? ({1'b0, delta} + {1'b0, prev_delta}) : {1'b0, delta};
      tword   = {1'b0, tmpl_word};
      diff    = (operand >= tword) ? (operand - tword) : (tword - operand);
      base    = ctl.first ? '0 : acc_ff;
      sum     = base + {4'b0, diff};
      hit     = (sum <= {6'b0, threshold});
      acc_in  = ctl.valid ? sum : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

FILE: src/counter_delta_template_matcher_unit.sv
// Top level of the counter delta template matcher
// A template load or a non-final counter reading is taken in the idle state, which it
// does not leave. A final reading closes the sample: a check state, then up to two search
// passes (plain, then previous-plus-current deltas) that stream the template RAM one word
// per cycle through the shared distance unit, then a finish state that posts the result
// once the output register is free. The single template RAM read port sets that rate.
// The input is not ready during a search; a posted result waits in the output register
// while new transfers are taken, and the next sample's result waits until it has been taken.
module counter_delta_template_matcher_unit (
   input  logic                          clock,
   input  logic                          reset,
   cdtm_req_if.sink                      req_ch,
   cdtm_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cdtm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [cdtm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [cdtm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   cdtm_pkg::cfg_type       cfg;
   cdtm_pkg::state_type     state_ff, state_in;
   cdtm_pkg::dist_ctl_type  dctl;

   // per-slot state
   logic [cdtm_pkg::CTR_W-1:0] prev_raw_ff [cdtm_pkg::SLOTS];
   logic [cdtm_pkg::CTR_W-1:0] staged_ff   [cdtm_pkg::SLOTS];
   logic [cdtm_pkg::CTR_W-1:0] last_rec_ff [cdtm_pkg::SLOTS];

   // history and event state
   logic                          record_present_ff;
   logic                          event_present_ff;
   logic [cdtm_pkg::TIME_W-1:0]   last_event_ff;
   logic [cdtm_pkg::HIST_W-1:0]   since_event_ff;
   logic                          change_seen_ff;
   logic [cdtm_pkg::TIME_W-1:0]   now_ff;

   // search sequencer
   logic                          pass_ff;
   logic                          iss_on_ff;
   logic [cdtm_pkg::ENTRY_W-1:0]  iss_e_ff;
   logic [cdtm_pkg::SLOT_W-1:0]   iss_s_ff;
   logic                          stg_vld_ff;
   logic [cdtm_pkg::ENTRY_W-1:0]  stg_e_ff;
   logic [cdtm_pkg::SLOT_W-1:0]   stg_s_ff;
   logic                          stg_end_ff;

   // working result and output register
   logic                          res_active_ff, res_supp_ff, res_match_ff, res_comb_ff;
   logic [cdtm_pkg::ENTRY_W-1:0]  res_entry_ff;
   logic                          rsp_valid_ff;
   logic                          out_active_ff, out_supp_ff, out_match_ff, out_comb_ff;
   logic [cdtm_pkg::ENTRY_W-1:0]  out_entry_ff;

   // combinational control
   logic                          req_fire, rsp_fire, out_free;
   logic                          slot_ok, rd_write, ld_write;
   logic [cdtm_pkg::CTR_W-1:0]    new_delta;
   logic [cdtm_pkg::COUNT_W-1:0]  n_eff, n_less;
   logic [cdtm_pkg::ENTRY_W-1:0]  last_e;
   logic                          supp_now, entry_done, hit, want_comb;
   logic                          do_start, do_restart, do_hit, do_post;
   logic [cdtm_pkg::TIME_W-1:0]   elapsed;
   logic [cdtm_pkg::CTR_W-1:0]    tmpl_word;
   logic [cdtm_pkg::HIST_W-1:0]   since_inc;

   cdtm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdtm_tmpl_ram u_ram (
      .clock   (clock),
      .wr_en   (ld_write),
      .wr_addr (cdtm_pkg::word_addr(req_ch.entry_index, req_ch.slot)),
      .wr_data (req_ch.value),
      .rd_addr (cdtm_pkg::word_addr(iss_e_ff, iss_s_ff)),
      .rd_data (tmpl_word)
   );

   cdtm_dist_unit u_dist (
      .clock      (clock),
      .ctl        (dctl),
      .tmpl_word  (tmpl_word),
      .delta      (staged_ff[stg_s_ff]),
      .prev_delta (last_rec_ff[stg_s_ff]),
      .threshold  (cfg.threshold),
      .hit        (hit)
   );

   // handshakes
   assign req_ch.ready = (state_ff == cdtm_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.active      = out_active_ff;
   assign rsp_ch.suppressed  = out_supp_ff;
   assign rsp_ch.matched     = out_match_ff;
   assign rsp_ch.via_combine = out_comb_ff;
   assign rsp_ch.match_entry = out_entry_ff;

   // input decode and delta
   always_comb begin
      slot_ok   = (req_ch.slot < cdtm_pkg::SLOT_LIMIT);
      rd_write  = req_fire && (req_ch.command == cdtm_pkg::CMD_READ) && slot_ok;
      ld_write  = req_fire && (req_ch.command == cdtm_pkg::CMD_LOAD) && slot_ok;
      new_delta = slot_ok ? (req_ch.value - prev_raw_ff[req_ch.slot]) : '0;
   end

   // search limits and hold-off test
   always_comb begin
      n_eff    = (cfg.entries > cdtm_pkg::ENTRY_MAX) ? cdtm_pkg::ENTRY_MAX : cfg.entries;
      n_less   = n_eff - 8'd1;
      last_e   = n_less[cdtm_pkg::ENTRY_W-1:0];
      elapsed  = now_ff - last_event_ff;
      supp_now = event_present_ff && (since_event_ff < cdtm_pkg::HIST_DEPTH) &&
                 ((now_ff < last_event_ff) || (elapsed <= {44'b0, cfg.hold_off}));
      entry_done = stg_vld_ff && (stg_s_ff == cdtm_pkg::SLOT_LAST);
      want_comb  = !pass_ff && record_present_ff;
      since_inc  = since_event_ff + 7'd1;
      dctl.valid    = stg_vld_ff;
      dctl.first    = (stg_s_ff == '0);
      dctl.use_prev = pass_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdtm_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.command == cdtm_pkg::CMD_READ) && req_ch.last_slot) begin
               state_in = cdtm_pkg::ST_CHECK;
            end
         end
         cdtm_pkg::ST_CHECK: begin
            if (!change_seen_ff || supp_now || (n_eff == '0)) begin
               state_in = cdtm_pkg::ST_FINISH;
            end else begin
               state_in = cdtm_pkg::ST_SEARCH;
            end
         end
         cdtm_pkg::ST_SEARCH: begin
            if (entry_done && (hit || (stg_end_ff && !want_comb))) begin
               state_in = cdtm_pkg::ST_FINISH;
            end
         end
         cdtm_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = cdtm_pkg::ST_IDLE;
            end
         end
         default: state_in = cdtm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_start   = 1'b0;
      do_restart = 1'b0;
      do_hit     = 1'b0;
      do_post    = 1'b0;
      case (state_ff)
         cdtm_pkg::ST_CHECK: begin
            do_start = change_seen_ff && !supp_now && (n_eff != '0);
         end
         cdtm_pkg::ST_SEARCH: begin
            do_hit     = entry_done && hit;
            do_restart = entry_done && !hit && stg_end_ff && want_comb;
         end
         cdtm_pkg::ST_FINISH: begin
            do_post = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdtm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-slot raw, staged and record deltas
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdtm_pkg::SLOTS; i++) begin
            prev_raw_ff[i] <= '0;
            staged_ff[i]   <= '0;
         end
         change_seen_ff <= 1'b0;
      end else if (rd_write) begin
         prev_raw_ff[req_ch.slot] <= req_ch.value;
         staged_ff[req_ch.slot]   <= new_delta;
         if (new_delta != '0) begin
            change_seen_ff <= 1'b1;
         end
      end else if (do_post) begin
         for (int i = 0; i < cdtm_pkg::SLOTS; i++) begin
            staged_ff[i] <= '0;
         end
         change_seen_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_post && res_active_ff) begin
         for (int i = 0; i < cdtm_pkg::SLOTS; i++) begin
            last_rec_ff[i] <= staged_ff[i];
         end
      end
   end

   // sample timestamp
   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff <= req_ch.time_us;
      end
   end

   // history and hold-off bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         record_present_ff <= 1'b0;
         event_present_ff  <= 1'b0;
         last_event_ff     <= '0;
         since_event_ff    <= '0;
      end else if (do_post && res_active_ff) begin
         record_present_ff <= 1'b1;
         if (res_match_ff) begin
            event_present_ff <= 1'b1;
            last_event_ff    <= now_ff;
            since_event_ff   <= '0;
         end else if (event_present_ff) begin
            if (since_inc >= cdtm_pkg::HIST_DEPTH) begin
               event_present_ff <= 1'b0;
               since_event_ff   <= '0;
            end else begin
               since_event_ff <= since_inc;
            end
         end
      end
   end

   // word issue and pipeline stage of the search
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_on_ff  <= 1'b0;
         stg_vld_ff <= 1'b0;
         pass_ff    <= 1'b0;
      end else if (do_start || do_restart) begin
         pass_ff    <= do_restart;
         iss_on_ff  <= 1'b1;
         iss_e_ff   <= '0;
         iss_s_ff   <= '0;
         stg_vld_ff <= 1'b0;
      end else if (do_hit || (state_ff != cdtm_pkg::ST_SEARCH)) begin
         iss_on_ff  <= 1'b0;
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= iss_on_ff;
         stg_e_ff   <= iss_e_ff;
         stg_s_ff   <= iss_s_ff;
         stg_end_ff <= (iss_e_ff == last_e);
         if (iss_on_ff) begin
            if (iss_s_ff == cdtm_pkg::SLOT_LAST) begin
               iss_s_ff <= '0;
               iss_e_ff <= iss_e_ff + 7'd1;
               if (iss_e_ff == last_e) begin
                  iss_on_ff <= 1'b0;
               end
            end else begin
               iss_s_ff <= iss_s_ff + 4'd1;
            end
         end
      end
   end

   // working result
   always_ff @(posedge clock) begin
      if (state_ff == cdtm_pkg::ST_CHECK) begin
         res_active_ff <= change_seen_ff;
         res_supp_ff   <= change_seen_ff && supp_now;
         res_match_ff  <= 1'b0;
         res_comb_ff   <= 1'b0;
         res_entry_ff  <= '0;
      end else if (do_hit) begin
         res_match_ff <= 1'b1;
         res_comb_ff  <= pass_ff;
         res_entry_ff <= stg_e_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_post) begin
         out_active_ff <= res_active_ff;
         out_supp_ff   <= res_supp_ff;
         out_match_ff  <= res_match_ff;
         out_comb_ff   <= res_comb_ff;
         out_entry_ff  <= res_entry_ff;
      end
   end

endmodule

FILE: src/cdtm_checker.sv
// Port-level checks of the matcher, bound to the top level
`include "assert_macros.svh"

module cdtm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          active,
   input logic                          suppressed,
   input logic                          matched,
   input logic                          via_combine,
   input logic [cdtm_pkg::ENTRY_W-1:0]  match_entry
);

   // a waiting result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // an idle sample reports nothing else
   `ASSERT_IMPLY(a_idle_quiet, clock, reset, rsp_valid && !active, !suppressed && !matched)
   // suppression and matching exclude each other
   `ASSERT_IMPLY(a_supp_nomatch, clock, reset, rsp_valid && suppressed, !matched)
   // no match means no entry and no combine flag
   `ASSERT_IMPLY(a_nomatch_zero, clock, reset, rsp_valid && !matched,
                 (match_entry == '0) && !via_combine)

endmodule

bind counter_delta_template_matcher_unit cdtm_checker u_cdtm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .active      (rsp_ch.active),
   .suppressed  (rsp_ch.suppressed),
   .matched     (rsp_ch.matched),
   .via_combine (rsp_ch.via_combine),
   .match_entry (rsp_ch.match_entry)
);
